@@ rtl/assert_macros.svh @@
// assertion macros shared by the star stencil filter rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SSF_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
// next-cycle implication
`define SSF_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`else
`define SSF_ASSERT_IMP(lbl, clk, rst, a, c)
`define SSF_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

@@ rtl/ssf3d_pkg.sv @@
// shared types and constants of the star stencil filter
// used by ssf3d_ctrl, ssf3d_datapath and star_stencil_filter_3d
package ssf3d_pkg;

  localparam int MAX_Y_DEF          = 64;
  localparam int MAX_Z_DEF          = 64;
  localparam int MAX_HALF_ORDER_DEF = 4;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] REG_SIZE_X     = 2'd0;
  localparam logic [1:0] REG_SIZE_Y     = 2'd1;
  localparam logic [1:0] REG_SIZE_Z     = 2'd2;
  localparam logic [1:0] REG_HALF_WIDTH = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         axis;
    logic [3:0]         tap;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic setup;
    logic run;
    logic rd_center;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic geom_busy;
    logic emit_req;
    logic inner;
    logic last_tap;
    logic last_axis;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

@@ rtl/ssf3d_ctrl.sv @@
// sequencer of the star stencil filter
// depends on ssf3d_pkg for the command and status structs
module ssf3d_ctrl import ssf3d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_EXEC   = 8'b00000010,
    S_SETUP  = 8'b00000100,
    S_RUN    = 8'b00001000,
    S_DRAIN  = 8'b00010000,
    S_PASS   = 8'b00100000,
    S_PASSW  = 8'b01000000,
    S_FINISH = 8'b10000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !st.geom_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.emit_req) begin
          state_next = st.inner ? S_SETUP : S_PASS;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (st.last_tap) begin
          state_next = st.last_axis ? S_DRAIN : S_SETUP;
        end
      end
      S_DRAIN: begin
        if (!st.pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_PASS: begin
        cmd.rd_center = 1'b1;
        state_next    = S_PASSW;
      end
      S_PASSW: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ssf3d_datapath.sv @@
// datapath of the star stencil filter: registers, geometry, plane memory,
// coefficient table, multiply-accumulate and output register; uses ssf3d_pkg
module ssf3d_datapath import ssf3d_pkg::*; #(
  parameter int MAX_Y          = MAX_Y_DEF,
  parameter int MAX_Z          = MAX_Z_DEF,
  parameter int MAX_HALF_ORDER = MAX_HALF_ORDER_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  in_beat_t  in_data,
  input  cmd_t      cmd,
  output status_t   st,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int TAPS  = 2 * MAX_HALF_ORDER + 1;
  localparam int TPW   = $clog2(TAPS);
  localparam int HW    = $clog2(MAX_HALF_ORDER + 1);
  localparam int YW    = $clog2(MAX_Y + 1);
  localparam int ZW    = $clog2(MAX_Z + 1);
  localparam int PW    = YW + ZW;
  localparam int HZW   = ZW + HW;
  localparam int HPW   = PW + HW;
  localparam int CNT_W = 16 + PW;
  localparam int DEPTH = TAPS * MAX_Y * MAX_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int AW1   = AW + 1;
  localparam int ACC_W = 50 + $clog2(3 * TAPS) + 1;
  localparam int QW    = ACC_W - 16;
  localparam int CW    = 17;

  // configuration registers
  logic [15:0] size_x;
  logic [6:0]  size_y, size_z;
  logic [2:0]  half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= 16'd1;
      size_y     <= 7'd64;
      size_z     <= 7'd64;
      half_width <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X:     size_x     <= cfg_data;
        REG_SIZE_Y:     size_y     <= cfg_data[6:0];
        REG_SIZE_Z:     size_z     <= cfg_data[6:0];
        REG_HALF_WIDTH: half_width <= cfg_data[2:0];
        default:        size_x     <= size_x;
      endcase
    end
  end

  // clamped geometry
  logic [15:0]   ex;
  logic [YW-1:0] ey;
  logic [ZW-1:0] ez;
  logic [HW-1:0] eh;
  logic          two_d;

  always_comb begin
    ex = (size_x == 16'd0) ? 16'd1 : size_x;
    if (size_y == 7'd0) begin
      ey = YW'(1);
    end else if (int'(size_y) > MAX_Y) begin
      ey = YW'(MAX_Y);
    end else begin
      ey = YW'(size_y);
    end
    if (size_z == 7'd0) begin
      ez = ZW'(1);
    end else if (int'(size_z) > MAX_Z) begin
      ez = ZW'(MAX_Z);
    end else begin
      ez = ZW'(size_z);
    end
    if (half_width == 3'd0) begin
      eh = HW'(1);
    end else if (int'(half_width) > MAX_HALF_ORDER) begin
      eh = HW'(MAX_HALF_ORDER);
    end else begin
      eh = HW'(half_width);
    end
    two_d = (ex == 16'd1);
  end

  // derived sizes, three register stages
  logic [PW-1:0]    plane;
  logic [HZW-1:0]   hz;
  logic [HPW-1:0]   hplane;
  logic [CNT_W-1:0] total, lag;
  logic [1:0]       settle;

  always_ff @(posedge clk) begin
    plane  <= PW'(ey) * PW'(ez);
    hz     <= HZW'(eh) * HZW'(ez);
    total  <= CNT_W'(ex) * CNT_W'(plane);
    hplane <= HPW'(eh) * HPW'(plane);
    lag    <= two_d ? CNT_W'(hz) : CNT_W'(hplane);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= 2'd3;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // item and volume counters
  in_beat_t         item;
  logic [CNT_W-1:0] samples_taken, results_given;
  logic [AW-1:0]    wptr, rptr;
  logic [15:0]      rx;
  logic [YW-1:0]    ry;
  logic [ZW-1:0]    rz;
  logic             is_sample, samp_ok, emit_req, load_ok, vol_end;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_data;
    end
  end

  always_comb begin
    is_sample = (item.func == FUNC_SAMPLE);
    samp_ok   = is_sample && (samples_taken < total);
    load_ok   = (item.func == FUNC_LOAD) && (item.axis <= AXIS_Z) && (int'(item.tap) < TAPS);
    emit_req  = (samp_ok && (samples_taken >= lag))
             || ((item.func == FUNC_FLUSH) && (samples_taken == total)
                 && (results_given < samples_taken));
    vol_end   = (results_given + CNT_W'(1)) >= total;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      samples_taken <= '0;
      results_given <= '0;
      wptr          <= '0;
      rptr          <= '0;
      rx            <= '0;
      ry            <= '0;
      rz            <= '0;
    end else if (cmd.exec && samp_ok) begin
      samples_taken <= samples_taken + CNT_W'(1);
      wptr          <= (int'(wptr) == DEPTH - 1) ? '0 : wptr + AW'(1);
    end else if (cmd.emit) begin
      if (vol_end) begin
        samples_taken <= '0;
        results_given <= '0;
        wptr          <= '0;
        rptr          <= '0;
        rx            <= '0;
        ry            <= '0;
        rz            <= '0;
      end else begin
        results_given <= results_given + CNT_W'(1);
        rptr          <= (int'(rptr) == DEPTH - 1) ? '0 : rptr + AW'(1);
        if (rz == ez - ZW'(1)) begin
          rz <= '0;
          if (ry == ey - YW'(1)) begin
            ry <= '0;
            rx <= rx + 16'd1;
          end else begin
            ry <= ry + YW'(1);
          end
        end else begin
          rz <= rz + ZW'(1);
        end
      end
    end
  end

  // interior test of the point about to be given
  logic inner;
  always_comb begin
    inner = (CW'(ry) >= CW'(eh)) && (CW'(ry) + CW'(eh) < CW'(ey))
         && (CW'(rz) >= CW'(eh)) && (CW'(rz) + CW'(eh) < CW'(ez));
    if (!two_d) begin
      inner = inner && (CW'(rx) >= CW'(eh)) && (CW'(rx) + CW'(eh) < CW'(ex));
    end
  end

  // coefficient table
  logic [17:0] coef [3][TAPS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        for (int t = 0; t < TAPS; t++) begin
          coef[a][t] <= '0;
        end
      end
    end else if (cmd.exec && load_ok) begin
      coef[item.axis][TPW'(item.tap)] <= item.value[17:0];
    end
  end

  // tap walker
  logic [1:0]     axis_cur;
  logic [TPW-1:0] tap_cur;
  logic [AW-1:0]  addr;
  logic [AW1-1:0] stride, hs, start, step;
  logic           last_tap, last_axis;

  always_comb begin
    case (axis_cur)
      AXIS_X: begin
        stride = AW1'(plane);
        hs     = AW1'(hplane);
      end
      AXIS_Y: begin
        stride = AW1'(ez);
        hs     = AW1'(hz);
      end
      default: begin
        stride = AW1'(1);
        hs     = AW1'(eh);
      end
    endcase
    start = (AW1'(rptr) >= hs) ? AW1'(rptr) - hs : AW1'(rptr) + AW1'(DEPTH) - hs;
    step  = AW1'(addr) + stride;
    if (step >= AW1'(DEPTH)) begin
      step = step - AW1'(DEPTH);
    end
    last_tap  = (tap_cur == TPW'({eh, 1'b0}));
    last_axis = (axis_cur == AXIS_Z);
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      axis_cur <= two_d ? AXIS_Y : AXIS_X;
    end else if (cmd.setup) begin
      tap_cur <= '0;
      addr    <= AW'(start);
    end else if (cmd.run) begin
      tap_cur <= tap_cur + TPW'(1);
      addr    <= AW'(step);
      if (last_tap && !last_axis) begin
        axis_cur <= axis_cur + 2'd1;
      end
    end
  end

  // plane memory, one write and one registered read port
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.exec && samp_ok) begin
      mem[wptr] <= item.value;
    end
    if (cmd.run || cmd.rd_center) begin
      rd_data <= mem[cmd.run ? addr : rptr];
    end
  end

  // multiply-accumulate pipeline
  logic                    v1, v2, pass;
  logic [17:0]             cf1;
  logic signed [49:0]      prod;
  logic signed [ACC_W-1:0] acc, acc_r;
  logic signed [QW-1:0]    q;
  logic [QW-32:0]          q_hi;
  logic [31:0]             rounded;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.run;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      cf1 <= coef[axis_cur][tap_cur];
    end
    if (v1) begin
      prod <= $signed(rd_data) * $signed(cf1);
    end
    if (cmd.exec) begin
      acc  <= '0;
      pass <= 1'b0;
    end else begin
      if (v2) begin
        acc <= acc + ACC_W'(prod);
      end
      if (cmd.rd_center) begin
        pass <= 1'b1;
      end
    end
  end

  // round half up to q16.16, then saturate
  always_comb begin
    acc_r   = acc + ACC_W'(32768);
    q       = QW'(acc_r >>> 16);
    q_hi    = q[QW-1:31];
    rounded = q[31:0];
    if (!((&q_hi) || !(|q_hi))) begin
      rounded = q[QW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.result <= pass ? rd_data : rounded;
      out_data.last   <= (results_given + CNT_W'(1)) == total;
    end
  end

  always_comb begin
    st.geom_busy = (settle != 2'd0);
    st.emit_req  = emit_req;
    st.inner     = inner;
    st.last_tap  = last_tap;
    st.last_axis = last_axis;
    st.pipe_busy = v1 || v2;
    st.out_free  = !out_valid || out_ready;
  end

endmodule

@@ rtl/star_stencil_filter_3d.sv @@
// top level of the 3d star stencil filter
// depends on ssf3d_pkg, ssf3d_ctrl, ssf3d_datapath and assert_macros.svh
//
//   channel  | signals                        | beat
//   ---------+--------------------------------+------------------------------
//   input    | in_valid in_ready in_data      | func, axis, tap, value
//   output   | out_valid out_ready out_data   | result, last
//   config   | cfg_we cfg_index cfg_data      | one register write, no wait
//
// one beat at a time; a load, a dropped sample or an idle flush ends after exec
// a border result reads its center point; an interior one walks 2h+1 taps
//   on each of A axes, A = 3 axes (2 in 2d mode), h = half width,
//   one tap per cycle through the single read port of the plane memory
// after reset and after each register write, input stalls while the plane
//   and volume sizes are recomputed
// a finished result waits in the output register; the next beat is taken
//   meanwhile and only the next result stalls on out_ready
`include "assert_macros.svh"
module star_stencil_filter_3d import ssf3d_pkg::*; #(
  parameter int MAX_Y          = MAX_Y_DEF,
  parameter int MAX_Z          = MAX_Z_DEF,
  parameter int MAX_HALF_ORDER = MAX_HALF_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data
);

  // sequencer commands and datapath status
  cmd_t    cmd;
  status_t st;

  // controller: walks load, sample, flush and the tap loop
  ssf3d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: window memory, coefficients, mac and output register
  ssf3d_datapath #(
    .MAX_Y          (MAX_Y),
    .MAX_Z          (MAX_Z),
    .MAX_HALF_ORDER (MAX_HALF_ORDER)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // only one beat in flight
  `SSF_ASSERT_NXT(a_one_beat, clk, rst, in_valid && in_ready, !in_ready)
  // a result never overwrites one still waiting
  `SSF_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.emit, !out_valid || out_ready)
  // geometry settles before the next beat is taken
  `SSF_ASSERT_NXT(a_cfg_settle, clk, rst, cfg_we, !in_ready)

endmodule
